FILE: hw/rtl/sct_pkg.sv
// Package for the source code tokenizer: payload structs, token kinds,
// error codes, character classes and keyword lookup. No dependencies.
package sct_pkg;

    localparam int LINE_BITS       = 20;
    localparam int COLUMN_BITS     = 16;
    localparam int KEYWORD_MAX_LEN = 6;

    localparam logic [1:0] EV_VALUE = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;
    localparam logic [1:0] EV_EOF   = 2'd3;

    localparam logic [5:0] K_IDENT  = 6'd0;
    localparam logic [5:0] K_TEXT   = 6'd1;
    localparam logic [5:0] K_INT    = 6'd2;
    localparam logic [5:0] K_DOUBLE = 6'd3;
    localparam logic [5:0] K_EQ     = 6'd9;
    localparam logic [5:0] K_NE     = 6'd10;
    localparam logic [5:0] K_LE     = 6'd13;
    localparam logic [5:0] K_GE     = 6'd15;
    localparam logic [5:0] K_ARROW  = 6'd23;
    localparam logic [5:0] K_FN     = 6'd25;
    localparam logic [5:0] K_LET    = 6'd26;
    localparam logic [5:0] K_CONST  = 6'd27;
    localparam logic [5:0] K_I32    = 6'd28;
    localparam logic [5:0] K_VOID   = 6'd29;
    localparam logic [5:0] K_RETURN = 6'd30;
    localparam logic [5:0] K_WHILE  = 6'd31;
    localparam logic [5:0] K_EOF    = 6'd32;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_BAD_CHAR = 3'd1;
    localparam logic [2:0] E_UNTERM   = 3'd2;
    localparam logic [2:0] E_ESCAPE   = 3'd3;
    localparam logic [2:0] E_HEX      = 3'd4;
    localparam logic [2:0] E_BIN      = 3'd5;
    localparam logic [2:0] E_FLOAT    = 3'd6;
    localparam logic [2:0] E_INTEGER  = 3'd7;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [1:0]             event_res;
        logic [5:0]             token_kind;
        logic [7:0]             value_char;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
        logic [2:0]             error_code;
        logic                   last_of_run;
    } t_out;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_dec_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex_char(input logic [7:0] c);
        return is_dec_char(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            "+":     return 6'd4;
            "-":     return 6'd5;
            "*":     return 6'd6;
            "/":     return 6'd7;
            "=":     return 6'd8;
            "!":     return 6'd11;
            "<":     return 6'd12;
            ">":     return 6'd14;
            "[":     return 6'd16;
            "]":     return 6'd17;
            "(":     return 6'd18;
            ")":     return 6'd19;
            "{":     return 6'd20;
            "}":     return 6'd21;
            ";":     return 6'd22;
            ",":     return 6'd24;
            default: return K_IDENT;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] f, input logic [7:0] s);
        if (s == "=" && f == "=") return K_EQ;
        if (s == "=" && f == "!") return K_NE;
        if (s == "=" && f == "<") return K_LE;
        if (s == "=" && f == ">") return K_GE;
        if (f == "-" && s == ">") return K_ARROW;
        return K_IDENT;
    endfunction

    // b holds the first six buffered bytes, first byte in the top position.
    function automatic logic [5:0] kw_kind(input logic [47:0] b, input logic [2:0] n);
        case (n)
            3'd2: if (b[47:32] == "fn") return K_FN;
            3'd3: begin
                if (b[47:24] == "let") return K_LET;
                if (b[47:24] == "i32") return K_I32;
            end
            3'd4: if (b[47:16] == "void") return K_VOID;
            3'd5: begin
                if (b[47:8] == "const") return K_CONST;
                if (b[47:8] == "while") return K_WHILE;
            end
            3'd6: if (b == "return") return K_RETURN;
            default: ;
        endcase
        return K_IDENT;
    endfunction

endpackage

FILE: hw/rtl/source_code_tokenizer.sv
// Source code tokenizer top level: scanner state, result generation and
// an eight-entry result queue. Depends on sct_pkg.
//
// One source byte (or an end marker) is taken per cycle and scanned in the
// cycle of its transfer; the up to three results it causes go into an
// eight-entry result queue that drains one result per cycle unless i_stall
// holds it. The input side stalls while more than four results wait, so the
// sustained rate is one byte per cycle as long as bytes average at most one
// result each; the queue drain sets the rate otherwise.
module source_code_tokenizer #(
    parameter int KEYWORD_MAX_LEN = sct_pkg::KEYWORD_MAX_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sct_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sct_pkg::t_out o_data
);
    import sct_pkg::*;

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam logic [LW-1:0] KW_LEN = LW'(KEYWORD_MAX_LEN);

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_IDENT, M_STR, M_ESC, M_ZERO, M_DEC, M_HEX, M_BIN, M_FLOAT
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic [7:0]             r_held, n_held;
    logic [7:0]             r_buf [KEYWORD_MAX_LEN];
    logic [7:0]             n_buf [KEYWORD_MAX_LEN];
    logic [LW-1:0]          r_len, n_len;
    logic [LINE_BITS-1:0]   r_line, n_line, r_ts_line, n_ts_line;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_ts_col, n_ts_col;

    t_out       r_fifo [8];
    logic [2:0] r_wr, r_rd;
    logic [3:0] r_cnt;

    t_out       res [4];
    logic [2:0] nres;
    logic       acc, pop;

    assign acc     = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_stall = r_cnt > 4'd4;
    assign o_valid = r_cnt != 4'd0;
    assign o_data  = r_fifo[r_rd];

    always_comb begin
        logic [7:0]  c;
        logic        rescan;
        logic [5:0]  k;
        logic [47:0] kb;
        c      = i_data.char_code;
        rescan = 1'b0;
        n_mode = r_mode;
        n_held = r_held;
        n_buf  = r_buf;
        n_len  = r_len;
        n_line = r_line;
        n_col  = r_col;
        n_ts_line = r_ts_line;
        n_ts_col  = r_ts_col;
        nres   = 3'd0;
        for (int i = 0; i < 4; i++) res[i] = '0;
        kb = '0;
        for (int j = 0; j < 6; j++) begin
            if (j < KEYWORD_MAX_LEN) kb[47-8*j -: 8] = r_buf[j];
        end
        // No keyword is longer than six bytes.
        k = (r_len > LW'(6)) ? K_IDENT : kw_kind(kb, r_len[2:0]);

        if (i_data.end_of_input) begin
            case (r_mode)
                M_OP:    begin res[0] = '{EV_DONE, single_kind(r_held), 8'd0, r_ts_line,
                                          r_ts_col, E_NONE, 1'b0}; nres = 3'd1; end
                M_IDENT: begin res[0] = '{EV_DONE, k, 8'd0, r_ts_line, r_ts_col,
                                          E_NONE, 1'b0}; nres = 3'd1; end
                M_STR:   begin res[0] = '{EV_ERROR, K_IDENT, 8'd0, r_ts_line, r_ts_col,
                                          E_UNTERM, 1'b0}; nres = 3'd1; end
                M_ESC:   begin res[0] = '{EV_ERROR, K_IDENT, 8'd0, r_ts_line, r_ts_col,
                                          E_ESCAPE, 1'b0}; nres = 3'd1; end
                M_ZERO, M_DEC, M_HEX, M_BIN: begin
                    res[0] = '{EV_DONE, K_INT, 8'd0, r_ts_line, r_ts_col, E_NONE, 1'b0};
                    nres = 3'd1;
                end
                M_FLOAT: begin res[0] = '{EV_DONE, K_DOUBLE, 8'd0, r_ts_line, r_ts_col,
                                          E_NONE, 1'b0}; nres = 3'd1; end
                default: ;
            endcase
            res[nres[1:0]] = '{EV_EOF, K_EOF, 8'd0, r_line, r_col, E_NONE, 1'b0};
            nres = nres + 3'd1;
            n_mode = M_IDLE;
            n_held = '0;
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) n_buf[j] = '0;
            n_len  = '0;
            n_line = LINE_BITS'(1);
            n_col  = '0;
            n_ts_line = LINE_BITS'(1);
            n_ts_col  = '0;
        end else begin
            if (r_col != '1) n_col = r_col + COLUMN_BITS'(1);
            if (c == 8'd10) begin
                if (r_line != '1) n_line = r_line + LINE_BITS'(1);
                n_col = '0;
            end
            case (r_mode)
                M_IDLE: rescan = 1'b1;
                M_OP: begin
                    if (pair_kind(r_held, c) != K_IDENT) begin
                        res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        res[1] = '{EV_DONE, pair_kind(r_held, c), 8'd0, r_ts_line, r_ts_col,
                                   E_NONE, 1'b0};
                        nres = 3'd2;
                        n_mode = M_IDLE;
                    end else begin
                        res[0] = '{EV_DONE, single_kind(r_held), 8'd0, r_ts_line, r_ts_col,
                                   E_NONE, 1'b0};
                        nres = 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_dec_char(c) || c == "_") begin
                        res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                            if (r_len == LW'(j)) n_buf[j] = c;
                        end
                        if (r_len <= KW_LEN) n_len = r_len + LW'(1);
                    end else begin
                        res[0] = '{EV_DONE, k, 8'd0, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == 8'h22) begin
                        res[0] = '{EV_DONE, K_TEXT, 8'd0, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        n_mode = M_IDLE;
                    end else if (c == 8'h5C) begin
                        n_mode = M_ESC;
                    end else begin
                        res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                    end
                end
                M_ESC: begin
                    res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                    nres = 3'd1;
                    n_mode = M_STR;
                end
                M_ZERO: begin
                    if (c == "x" || c == "X" || c == "b" || c == "B" || c == ".") begin
                        res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        n_mode = (c == ".") ? M_FLOAT :
                                 (c == "x" || c == "X") ? M_HEX : M_BIN;
                    end else if (is_dec_char(c)) begin
                        res[0] = '{EV_ERROR, K_IDENT, c, r_ts_line, r_ts_col, E_INTEGER,
                                   1'b0};
                        nres = 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[0] = '{EV_DONE, K_INT, 8'd0, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_DEC, M_FLOAT: begin
                    if (is_dec_char(c) || (r_mode == M_DEC && c == ".")) begin
                        res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        if (c == ".") n_mode = M_FLOAT;
                    end else if (c == ".") begin
                        res[0] = '{EV_ERROR, K_IDENT, c, r_ts_line, r_ts_col, E_FLOAT, 1'b0};
                        nres = 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[0] = '{EV_DONE, (r_mode == M_DEC) ? K_INT : K_DOUBLE, 8'd0,
                                   r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_HEX: begin
                    if (is_hex_char(c)) begin
                        res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                    end else if (is_alpha(c)) begin
                        res[0] = '{EV_ERROR, K_IDENT, c, r_ts_line, r_ts_col, E_HEX, 1'b0};
                        nres = 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[0] = '{EV_DONE, K_INT, 8'd0, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        rescan = 1'b1;
                    end
                end
                M_BIN: begin
                    if (c == "0" || c == "1") begin
                        res[0] = '{EV_VALUE, K_IDENT, c, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                    end else if (is_dec_char(c)) begin
                        res[0] = '{EV_ERROR, K_IDENT, c, r_ts_line, r_ts_col, E_BIN, 1'b0};
                        nres = 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[0] = '{EV_DONE, K_INT, 8'd0, r_ts_line, r_ts_col, E_NONE, 1'b0};
                        nres = 3'd1;
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase

            // A byte that ended the previous token is scanned again from idle.
            if (rescan) begin
                n_mode = M_IDLE;
                if (!is_space(c)) begin
                    n_ts_line = n_line;
                    n_ts_col  = n_col;
                    if (c == "=" || c == "!" || c == "<" || c == ">" || c == "-") begin
                        res[nres[1:0]] = '{EV_VALUE, K_IDENT, c, n_line, n_col, E_NONE, 1'b0};
                        nres = nres + 3'd1;
                        n_held = c;
                        n_mode = M_OP;
                    end else if (single_kind(c) != K_IDENT) begin
                        res[nres[1:0]] = '{EV_VALUE, K_IDENT, c, n_line, n_col, E_NONE, 1'b0};
                        nres = nres + 3'd1;
                        res[nres[1:0]] = '{EV_DONE, single_kind(c), 8'd0, n_line, n_col,
                                           E_NONE, 1'b0};
                        nres = nres + 3'd1;
                    end else if (is_alpha(c) || c == "_") begin
                        res[nres[1:0]] = '{EV_VALUE, K_IDENT, c, n_line, n_col, E_NONE, 1'b0};
                        nres = nres + 3'd1;
                        for (int j = 0; j < KEYWORD_MAX_LEN; j++) n_buf[j] = '0;
                        n_buf[0] = c;
                        n_len  = LW'(1);
                        n_mode = M_IDENT;
                    end else if (c == 8'h22) begin
                        n_mode = M_STR;
                    end else if (is_dec_char(c)) begin
                        res[nres[1:0]] = '{EV_VALUE, K_IDENT, c, n_line, n_col, E_NONE, 1'b0};
                        nres = nres + 3'd1;
                        n_mode = (c == "0") ? M_ZERO : M_DEC;
                    end else begin
                        res[nres[1:0]] = '{EV_ERROR, K_IDENT, c, n_line, n_col, E_BAD_CHAR,
                                           1'b0};
                        nres = nres + 3'd1;
                    end
                end
            end
        end
        if (nres != 3'd0) res[2'(nres - 3'd1)].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_held <= '0;
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) r_buf[j] <= '0;
            r_len  <= '0;
            r_line <= LINE_BITS'(1);
            r_col  <= '0;
            r_ts_line <= LINE_BITS'(1);
            r_ts_col  <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (acc) begin
                r_mode <= n_mode;
                r_held <= n_held;
                r_buf  <= n_buf;
                r_len  <= n_len;
                r_line <= n_line;
                r_col  <= n_col;
                r_ts_line <= n_ts_line;
                r_ts_col  <= n_ts_col;
                r_wr <= r_wr + nres;
            end
            if (pop) r_rd <= r_rd + 3'd1;
            r_cnt <= r_cnt + (acc ? {1'b0, nres} : 4'd0) - (pop ? 4'd1 : 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < nres) r_fifo[r_wr + 3'(i)] <= res[i];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd8) else $error("result queue overflow");
    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_data.end_of_input) |=> (r_mode == M_IDLE && r_col == '0))
        else $error("end marker did not reset scanner");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 4'd0 || r_cnt == 4'd8) |-> r_wr == r_rd)
        else $error("queue pointers disagree with count");
    a_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_data.end_of_input && r_mode == M_IDLE) |-> nres <= 3'd2)
        else $error("too many results from idle");

endmodule

FILE: tb/tb_source_code_tokenizer.sv
// Testbench for source_code_tokenizer: drives byte streams through the valid/stall
// handshake and checks every result against a cycle-free scanner prediction.
// Depends on sct_pkg and the source_code_tokenizer RTL.
module tb_source_code_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;
    import sct_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int COL_MAX     = (1 << COLUMN_BITS) - 1;
    localparam int LINE_MAX    = (1 << LINE_BITS) - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_OP, S_IDENT, S_STR, S_ESC, S_ZERO, S_DEC, S_HEX, S_BIN, S_FLOAT
    } scan_state_e;

    typedef enum int { STALL_NONE, STALL_RANDOM, STALL_PERIODIC } stall_mode_e;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_in   i_data  = '0;
    logic  o_stall;
    logic  o_valid;
    t_out  o_data;

    source_code_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Scanner prediction state.
    scan_state_e            mode;
    logic [7:0]             held_op;
    logic [7:0]             word_buf [6];
    int                     word_len;
    logic [LINE_BITS-1:0]   line_cnt;
    logic [COLUMN_BITS-1:0] col_cnt;
    logic [LINE_BITS-1:0]   tok_line;
    logic [COLUMN_BITS-1:0] tok_col;

    t_out step_tokens[$];
    t_out expected_tokens[$];

    int          fail_count  = 0;
    int          cycle_count = 0;
    int          hold_left   = 0;
    stall_mode_e stall_mode  = STALL_NONE;
    bit          gaps_on     = 1'b0;
    int          burst_left  = 0;
    int          items_sent  = 0;
    logic [7:0]  frag[$];

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_hexnum(logic [7:0] c);
        return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] c);
        case (c)
            "+": return 6'd4;
            "-": return 6'd5;
            "*": return 6'd6;
            "/": return 6'd7;
            "=": return 6'd8;
            "!": return 6'd11;
            "<": return 6'd12;
            ">": return 6'd14;
            "[": return 6'd16;
            "]": return 6'd17;
            "(": return 6'd18;
            ")": return 6'd19;
            "{": return 6'd20;
            "}": return 6'd21;
            ";": return 6'd22;
            ",": return 6'd24;
            default: return K_IDENT;
        endcase
    endfunction

    function automatic logic [5:0] op_pair_kind(logic [7:0] a, logic [7:0] b);
        if (b == "=") begin
            if (a == "=") return K_EQ;
            if (a == "!") return K_NE;
            if (a == "<") return K_LE;
            if (a == ">") return K_GE;
        end
        if (a == "-" && b == ">") return K_ARROW;
        return K_IDENT;
    endfunction

    function automatic logic [5:0] word_kind();
        logic [47:0] w;
        w = {word_buf[0], word_buf[1], word_buf[2], word_buf[3], word_buf[4], word_buf[5]};
        if (word_len == 2 && w == {"fn", 32'd0}) return K_FN;
        if (word_len == 3 && w == {"let", 24'd0}) return K_LET;
        if (word_len == 3 && w == {"i32", 24'd0}) return K_I32;
        if (word_len == 4 && w == {"void", 16'd0}) return K_VOID;
        if (word_len == 5 && w == {"const", 8'd0}) return K_CONST;
        if (word_len == 5 && w == {"while", 8'd0}) return K_WHILE;
        if (word_len == 6 && w == "return") return K_RETURN;
        return K_IDENT;
    endfunction

    task automatic reset_scanner();
        mode     = S_IDLE;
        held_op  = '0;
        foreach (word_buf[i]) word_buf[i] = '0;
        word_len = 0;
        line_cnt = LINE_BITS'(1);
        col_cnt  = '0;
        tok_line = LINE_BITS'(1);
        tok_col  = '0;
    endtask

    task automatic add_token(logic [1:0] ev, logic [5:0] kind, logic [7:0] ch,
                             logic [LINE_BITS-1:0] ln, logic [COLUMN_BITS-1:0] cl,
                             logic [2:0] ec);
        t_out r;
        r.event_res     = ev;
        r.token_kind    = kind;
        r.value_char    = ch;
        r.line_number   = ln;
        r.column_number = cl;
        r.error_code    = ec;
        r.last_of_run   = 1'b0;
        step_tokens.push_back(r);
    endtask

    task automatic add_value(logic [7:0] c);
        add_token(EV_VALUE, K_IDENT, c, tok_line, tok_col, E_NONE);
    endtask

    task automatic close_token(logic [5:0] kind);
        add_token(EV_DONE, kind, 8'd0, tok_line, tok_col, E_NONE);
        mode = S_IDLE;
    endtask

    task automatic abort_token(logic [2:0] ec, logic [7:0] c);
        add_token(EV_ERROR, K_IDENT, c, tok_line, tok_col, ec);
        mode = S_IDLE;
    endtask

    task automatic start_token(logic [7:0] c);
        logic [5:0] k;
        if (is_blank(c)) return;
        tok_line = line_cnt;
        tok_col  = col_cnt;
        if (c == "=" || c == "!" || c == "<" || c == ">" || c == "-") begin
            add_value(c);
            held_op = c;
            mode    = S_OP;
            return;
        end
        k = op_kind(c);
        if (k != K_IDENT) begin
            add_value(c);
            close_token(k);
        end else if (is_letter(c) || c == "_") begin
            add_value(c);
            foreach (word_buf[i]) word_buf[i] = '0;
            word_buf[0] = c;
            word_len    = 1;
            mode        = S_IDENT;
        end else if (c == "\"") begin
            mode = S_STR;
        end else if (c == "0") begin
            add_value(c);
            mode = S_ZERO;
        end else if (is_num(c)) begin
            add_value(c);
            mode = S_DEC;
        end else begin
            abort_token(E_BAD_CHAR, c);
        end
    endtask

    // Continues the token in progress; a byte that ends it is rescanned from idle.
    task automatic continue_token(logic [7:0] c);
        logic [5:0] k;
        case (mode)
            S_OP: begin
                k = op_pair_kind(held_op, c);
                if (k != K_IDENT) begin
                    add_value(c);
                    close_token(k);
                    return;
                end
                close_token(op_kind(held_op));
            end
            S_IDENT: begin
                if (is_letter(c) || is_num(c) || c == "_") begin
                    add_value(c);
                    if (word_len < KEYWORD_MAX_LEN) word_buf[word_len] = c;
                    if (word_len <= KEYWORD_MAX_LEN) word_len++;
                    return;
                end
                close_token(word_kind());
            end
            S_STR: begin
                if (c == "\"") close_token(K_TEXT);
                else if (c == "\\") mode = S_ESC;
                else add_value(c);
                return;
            end
            S_ESC: begin
                add_value(c);
                mode = S_STR;
                return;
            end
            S_ZERO: begin
                if (c == "x" || c == "X") begin
                    add_value(c);
                    mode = S_HEX;
                    return;
                end
                if (c == "b" || c == "B") begin
                    add_value(c);
                    mode = S_BIN;
                    return;
                end
                if (c == ".") begin
                    add_value(c);
                    mode = S_FLOAT;
                    return;
                end
                if (is_num(c)) begin
                    abort_token(E_INTEGER, c);
                    return;
                end
                close_token(K_INT);
            end
            S_DEC: begin
                if (is_num(c)) begin
                    add_value(c);
                    return;
                end
                if (c == ".") begin
                    add_value(c);
                    mode = S_FLOAT;
                    return;
                end
                close_token(K_INT);
            end
            S_HEX: begin
                if (is_hexnum(c)) begin
                    add_value(c);
                    return;
                end
                if (is_letter(c)) begin
                    abort_token(E_HEX, c);
                    return;
                end
                close_token(K_INT);
            end
            S_BIN: begin
                if (c == "0" || c == "1") begin
                    add_value(c);
                    return;
                end
                if (is_num(c)) begin
                    abort_token(E_BIN, c);
                    return;
                end
                close_token(K_INT);
            end
            S_FLOAT: begin
                if (is_num(c)) begin
                    add_value(c);
                    return;
                end
                if (c == ".") begin
                    abort_token(E_FLOAT, c);
                    return;
                end
                close_token(K_DOUBLE);
            end
            default: mode = S_IDLE;
        endcase
        start_token(c);
    endtask

    task automatic predict_tokens(t_in d);
        t_out r;
        step_tokens.delete();
        if (d.end_of_input) begin
            case (mode)
                S_OP:    close_token(op_kind(held_op));
                S_IDENT: close_token(word_kind());
                S_STR:   abort_token(E_UNTERM, 8'd0);
                S_ESC:   abort_token(E_ESCAPE, 8'd0);
                S_ZERO, S_DEC, S_HEX, S_BIN: close_token(K_INT);
                S_FLOAT: close_token(K_DOUBLE);
                default: ;
            endcase
            add_token(EV_EOF, K_EOF, 8'd0, line_cnt, col_cnt, E_NONE);
            reset_scanner();
        end else begin
            if (col_cnt != COL_MAX) col_cnt++;
            if (d.char_code == "\n") begin
                if (line_cnt != LINE_MAX) line_cnt++;
                col_cnt = '0;
            end
            if (mode == S_IDLE) start_token(d.char_code);
            else continue_token(d.char_code);
        end
        if (step_tokens.size() > 0) begin
            r = step_tokens.pop_back();
            r.last_of_run = 1'b1;
            step_tokens.push_back(r);
        end
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endtask

    // One input transfer; the sender then may open a gap between bursts.
    task automatic send_byte(logic [7:0] c, bit eoi);
        t_in d;
        d.char_code    = c;
        d.end_of_input = eoi;
        i_data  <= d;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_tokens(d);
        items_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(0, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_token(t_out got);
        t_out exp_r;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            fail_count++;
            return;
        end
        exp_r = expected_tokens.pop_front();
        check_field("event_res", 32'(exp_r.event_res), 32'(got.event_res));
        check_field("token_kind", 32'(exp_r.token_kind), 32'(got.token_kind));
        check_field("value_char", 32'(exp_r.value_char), 32'(got.value_char));
        check_field("line_number", 32'(exp_r.line_number), 32'(got.line_number));
        check_field("column_number", 32'(exp_r.column_number), 32'(got.column_number));
        check_field("error_code", 32'(exp_r.error_code), 32'(got.error_code));
        check_field("last_of_run", 32'(exp_r.last_of_run), 32'(got.last_of_run));
    endtask

    // Receiver: checks each result transfer and drives its own stall pattern.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("source_code_tokenizer: mismatch");
            $finish;
        end else begin
            if (i_rst_n && o_valid && !i_stall) check_token(o_data);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                case (stall_mode)
                    STALL_RANDOM:   i_stall <= ($urandom_range(0, 99) < 35);
                    STALL_PERIODIC: i_stall <= (cycle_count % 7 < 3);
                    default:        i_stall <= 1'b0;
                endcase
            end
        end
    end

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Builds one mostly well-formed token with random content, plus an optional separator.
    task automatic make_fragment();
        string letters;
        string keywords[7];
        int n;
        logic [7:0] c;
        letters  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        keywords = '{"fn", "let", "const", "i32", "void", "return", "while"};
        frag.delete();
        case ($urandom_range(0, 13))
            0, 1: begin
                frag.push_back(pick(letters));
                repeat ($urandom_range(0, 8))
                    frag.push_back($urandom_range(0, 3) == 0 ? pick("0123456789")
                                                           : pick(letters));
            end
            2: begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < keywords[n].len(); i++) frag.push_back(keywords[n][i]);
            end
            3: begin
                frag.push_back(pick("123456789"));
                repeat ($urandom_range(0, 4)) frag.push_back(pick("0123456789"));
            end
            4: begin
                frag.push_back("0");
                frag.push_back(pick("xX"));
                repeat ($urandom_range(0, 4)) frag.push_back(pick("0123456789abcdefABCDEF"));
                if ($urandom_range(0, 3) == 0) frag.push_back(pick("gGzZ"));
            end
            5: begin
                frag.push_back("0");
                frag.push_back(pick("bB"));
                repeat ($urandom_range(0, 5)) frag.push_back(pick("01"));
                if ($urandom_range(0, 3) == 0) frag.push_back(pick("23456789"));
            end
            6: begin
                frag.push_back(pick("0123456789"));
                frag.push_back(".");
                repeat ($urandom_range(0, 3)) frag.push_back(pick("0123456789"));
                if ($urandom_range(0, 3) == 0) frag.push_back(".");
            end
            7: begin
                frag.push_back("0");
                if ($urandom_range(0, 1) == 1) frag.push_back(pick("0123456789"));
            end
            8, 9: begin
                frag.push_back(pick("+-*/=!<>[](){};,"));
                if ($urandom_range(0, 1) == 1) frag.push_back(pick("=>"));
            end
            10: begin
                frag.push_back("\"");
                repeat ($urandom_range(0, 6)) begin
                    c = 8'($urandom_range(1, 255));
                    if (c == "\"") c = "\n";
                    if (c == "\\" || $urandom_range(0, 5) == 0) begin
                        frag.push_back("\\");
                        frag.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        frag.push_back(c);
                    end
                end
                if ($urandom_range(0, 7) != 0) frag.push_back("\"");
            end
            11: frag.push_back(8'($urandom_range(0, 255)));
            12: repeat ($urandom_range(1, 3)) frag.push_back(pick(" \t\n\r"));
            default: frag.push_back(8'($urandom_range(128, 255)));
        endcase
        if ($urandom_range(0, 1) == 1) frag.push_back(pick(" \n\t"));
    endtask

    task automatic test_directed();
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        send_text("fn x->y!=<=\"a\\q\"0X1g 0b3 07 1.2.@");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_text("ab\"z");
        send_byte(8'hA5, 1'b1);
        send_text("\"\\");
        send_byte(8'h5A, 1'b1);
        wait_drain();
    endtask

    // The receiver holds off while the sender keeps offering result-heavy bytes.
    task automatic test_backpressure();
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        @(posedge i_clk);
        hold_left = 300;
        repeat (6) send_text("(){};,+*");
        send_byte(8'h00, 1'b1);
        wait_drain();
    endtask

    task automatic test_random();
        int goal;
        goal       = items_sent + 140;
        gaps_on    = 1'b1;
        burst_left = $urandom_range(0, 12);
        while (items_sent < goal) begin
            case ((items_sent / 50) % 3)
                0: stall_mode = STALL_RANDOM;
                1: stall_mode = STALL_NONE;
                default: stall_mode = STALL_PERIODIC;
            endcase
            if ($urandom_range(0, 29) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                make_fragment();
                foreach (frag[i]) send_byte(frag[i], 1'b0);
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_drain();
    endtask

    initial begin
        reset_scanner();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("source_code_tokenizer: match");
        end else begin
            $display("source_code_tokenizer: mismatch");
        end
        $finish;
    end

endmodule
